FILE: design/ud_pkg.sv
// Shared types, character codes and helpers for the URL percent decoder.
package ud_pkg;

   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_SPACE   = 8'h20;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      HOLD_NONE  = 2'd0,
      HOLD_PCT   = 2'd1,
      HOLD_DIGIT = 2'd2
   } hold_state_type;

   // One classified input byte: up to three output bytes, in this order.
   typedef struct packed {
      logic       has_pct;
      logic       has_dig;
      logic [7:0] dig;
      logic       has_main;
      logic [7:0] main_byte;
      logic       last;
   } cmd_type;

   function automatic logic is_hex(input logic [7:0] c);
      is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
      else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h41 + 8'd10;
      else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h61 + 8'd10;
      hex_value = v[3:0];
   endfunction

endpackage

FILE: design/ud_front.sv
// Front end: accepts encoded bytes, tracks pending escapes, emits commands.
module ud_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [7:0]      req_in_byte,
   input  logic            req_in_last,
   input  logic            q_full,
   output logic            push,
   output ud_pkg::cmd_type push_cmd
);
   import ud_pkg::*;

   hold_state_type state_ff, state_in;
   logic [7:0]     digit_ff, digit_in;
   logic           accept;
   logic           byte_hex;
   logic           any_out;
   cmd_type        cmd;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign byte_hex  = is_hex(req_in_byte);

   // Next hold state.
   always_comb begin
      state_in = state_ff;
      digit_in = digit_ff;
      if (accept) begin
         unique case (state_ff)
            HOLD_PCT: begin
               if (byte_hex && !req_in_last) begin
                  state_in = HOLD_DIGIT;
                  digit_in = req_in_byte;
               end else if (req_in_byte == CH_PERCENT && !req_in_last) begin
                  state_in = HOLD_PCT;
               end else begin
                  state_in = HOLD_NONE;
               end
            end
            HOLD_DIGIT: begin
               if (!byte_hex && req_in_byte == CH_PERCENT && !req_in_last) begin
                  state_in = HOLD_PCT;
               end else begin
                  state_in = HOLD_NONE;
               end
            end
            default: begin
               if (req_in_byte == CH_PERCENT && !req_in_last) begin
                  state_in = HOLD_PCT;
               end else begin
                  state_in = HOLD_NONE;
               end
            end
         endcase
      end
   end

   // Command for this byte.
   always_comb begin
      cmd           = '0;
      cmd.dig       = digit_ff;
      cmd.main_byte = req_in_byte;
      cmd.last      = req_in_last;
      cmd.has_main  = !(req_in_byte == CH_PERCENT && !req_in_last);
      if (req_in_byte == CH_PLUS) cmd.main_byte = CH_SPACE;
      unique case (state_ff)
         HOLD_PCT: begin
            if (byte_hex && !req_in_last) begin
               cmd.has_main = 1'b0;
            end else begin
               cmd.has_pct = 1'b1;
            end
         end
         HOLD_DIGIT: begin
            if (byte_hex) begin
               cmd.has_main  = 1'b1;
               cmd.main_byte = {hex_value(digit_ff), hex_value(req_in_byte)};
            end else begin
               cmd.has_pct = 1'b1;
               cmd.has_dig = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign any_out  = cmd.has_pct || cmd.has_dig || cmd.has_main;
   assign push     = accept && any_out;
   assign push_cmd = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= HOLD_NONE;
         digit_ff <= 8'h00;
      end else begin
         state_ff <= state_in;
         digit_ff <= digit_in;
      end
   end

endmodule

FILE: design/ud_fifo.sv
// Short command queue between front and back end.
module ud_fifo (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  ud_pkg::cmd_type push_cmd,
   input  logic            pop,
   output logic            full,
   output logic            empty,
   output ud_pkg::cmd_type head_cmd
);
   import ud_pkg::*;

   cmd_type             mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: design/ud_back.sv
// Back end: expands each command into output bytes through an output register.
module ud_back (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_empty,
   input  ud_pkg::cmd_type head_cmd,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_out_last
);
   import ud_pkg::*;

   logic [1:0] done_ff, done_in;   // bit 0: '%' sent, bit 1: held digit sent
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       load;
   logic       rem_pct, rem_dig;
   logic       final_out;
   logic [1:0] sel_mask;

   assign rem_pct = head_cmd.has_pct && !done_ff[0];
   assign rem_dig = head_cmd.has_dig && !done_ff[1];
   assign load    = !q_empty && (!valid_ff || rsp_ready);

   always_comb begin
      byte_in  = byte_ff;
      last_in  = last_ff;
      sel_mask = 2'b00;
      if (rem_pct) begin
         sel_mask  = 2'b01;
         final_out = !head_cmd.has_dig && !head_cmd.has_main;
         if (load) begin
            byte_in = CH_PERCENT;
            last_in = 1'b0;
         end
      end else if (rem_dig) begin
         sel_mask  = 2'b10;
         final_out = !head_cmd.has_main;
         if (load) begin
            byte_in = head_cmd.dig;
            last_in = 1'b0;
         end
      end else begin
         final_out = 1'b1;
         if (load) begin
            byte_in = head_cmd.main_byte;
            last_in = head_cmd.last;
         end
      end
   end

   assign pop = load && final_out;

   always_comb begin
      done_in = done_ff;
      if (pop)       done_in = 2'b00;
      else if (load) done_in = done_ff | sel_mask;
      if (load)           valid_in = 1'b1;
      else if (rsp_ready) valid_in = 1'b0;
      else                valid_in = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff  <= 2'b00;
         valid_ff <= 1'b0;
      end else begin
         done_ff  <= done_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_out_last = last_ff;

endmodule

FILE: design/url_percent_decoder_core.sv
// Top level of the URL percent decoder: front end, command queue, back end.
//
// Usage:
//   req_* takes one encoded byte per transfer (req_in_byte, req_in_last marks
//   the final byte of a string). rsp_* gives one decoded byte per transfer;
//   rsp_out_last marks the final decoded byte of the string.
//   '+' becomes a space, '%' plus two hex digits becomes the spelled byte,
//   broken or cut-off escapes come out literally.
// Output path: a byte that completes an output is written into the command
//   queue and then loaded into the output register, which raises rsp_valid.
//   Bytes that only extend a pending escape produce nothing until the escape
//   resolves.
// Throughput: one input byte per cycle while the receiver is ready and each
//   byte yields at most one output. A byte that flushes a broken escape gives
//   one to three outputs; the single output register sends one per cycle and
//   the four-entry command queue absorbs the burst before req_ready drops.
// Reset: clears the pending-escape state, the queue and the output valid flag.
// Receiver stall: the output register holds its byte; the queue fills and
//   req_ready falls once it holds four commands.
module url_percent_decoder_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last
);
   import ud_pkg::*;

   logic    q_full;
   logic    q_empty;
   logic    push;
   logic    pop;
   cmd_type push_cmd;
   cmd_type head_cmd;

   // Classify each byte against the pending escape; push a command when
   // the byte causes output.
   ud_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .q_full      (q_full),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   // Decouple front and back so each can stall on its own.
   ud_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (q_full),
      .empty    (q_empty),
      .head_cmd (head_cmd)
   );

   // Drain commands one output byte per transfer.
   ud_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .head_cmd     (head_cmd),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

endmodule

FILE: design/ud_checker.sv
// Port-level checks for the URL percent decoder, bound to the top level.
module ud_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_last
);

   // Hold a stalled result steady.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_out_last))
      else $error("stalled result changed");

   // Drop valid only after a transfer.
   a_rsp_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid) |-> $past(rsp_ready))
      else $error("result withdrawn without transfer");

   // Empty output register implies the queue has room.
   a_ready_when_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while output register empty");

   // Come out of reset with no result pending.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind url_percent_decoder_core ud_checker u_ud_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_out_byte (rsp_out_byte),
   .rsp_out_last (rsp_out_last)
);
